// ===== rtl/core/ascii_frame_receiver_with_error_led_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ASCII frame receiver
// Shared forms of concurrent checks, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASCII_FRAME_RECEIVER_WITH_ERROR_LED_ASSERT_SVH
`define ASCII_FRAME_RECEIVER_WITH_ERROR_LED_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/afr_pkg.sv =====
// ----------------------------------------------------------------------------
// ASCII frame receiver package
// Types, character codes and helper functions shared by the receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package afr_pkg;

    // Frame buffer size in bytes, start mark and newline included.
    localparam logic [7:0] BUFFER_DEPTH = 8'd16;

    localparam logic [7:0]  CH_START   = 8'h3A;
    localparam logic [7:0]  CH_NEWLINE = 8'h0A;
    localparam logic [7:0]  CH_HASH    = 8'h23;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    localparam logic [7:0]  RESET_FRAME_LENGTH = 8'd13;
    localparam logic [15:0] RESET_LED_HOLD     = 16'd1000;

    localparam int CFG_INDEX_W = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_LENGTH = 1'b0,
        REG_LED_HOLD     = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_LENGTH = 3'd1,
        ST_NO_START   = 3'd2,
        ST_NO_END     = 3'd3,
        ST_BAD_CHAR   = 3'd4
    } frame_status_t;

    typedef struct packed {
        logic        frame_done;
        logic [2:0]  frame_status;
        logic        error_counted;
        logic [15:0] error_total;
        logic        led_lit;
    } result_t;

    typedef struct packed {
        logic        tick;
        logic [15:0] count;
        logic [15:0] hold;
    } led_req_t;

    // Digits, capital letters and the hash mark are legal inside a frame.
    function automatic logic char_allowed(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) ||
               (c == CH_HASH);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/afr_in_if.sv =====
// ----------------------------------------------------------------------------
// Input channel interface
// Carries received bytes and millisecond ticks into the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

interface afr_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/afr_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel interface
// Carries one result per accepted request out of the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

interface afr_out_if;
    logic        valid;
    logic        ready;
    logic        frame_done;
    logic [2:0]  frame_status;
    logic        error_counted;
    logic [15:0] error_total;
    logic        led_lit;

    modport source (output valid, output frame_done, output frame_status,
                    output error_counted, output error_total, output led_lit,
                    input ready);
    modport sink   (input valid, input frame_done, input frame_status,
                    input error_counted, input error_total, input led_lit,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/afr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write interface
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface afr_cfg_if;
    import afr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [15:0]            data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/afr_led_ctrl.sv =====
// ----------------------------------------------------------------------------
// Error LED controller
// Lights the LED, counting the hold time down in ticks, when a tick finds the error count changed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ascii_frame_receiver_with_error_led_assert.svh"

module afr_led_ctrl
    import afr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire led_req_t req,
    output logic          led_lit
);

    logic [15:0] seen_reg;
    logic [15:0] seen_next;
    logic [15:0] timer_reg;
    logic [15:0] timer_next;
    logic        led_reg;
    logic        led_next;

    logic        changed;
    logic [15:0] timer_load;
    logic        led_load;

    always_comb
    begin
        changed    = (req.count != seen_reg);
        timer_load = changed ? req.hold : timer_reg;
        led_load   = changed | led_reg;

        seen_next  = seen_reg;
        timer_next = timer_reg;
        led_next   = led_reg;
        if (req.tick)
        begin
            seen_next  = req.count;
            timer_next = (timer_load != 16'd0) ? (timer_load - 16'd1) : 16'd0;
            led_next   = led_load && (timer_next != 16'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            timer_reg <= '0;
            led_reg   <= 1'b0;
        end
        else
        begin
            seen_reg  <= seen_next;
            timer_reg <= timer_next;
            led_reg   <= led_next;
        end
    end

    // A byte leaves the LED alone, so the result shows the updated state either way.
    assign led_lit = led_next;

    `AFR_ASSERT_SAME(a_led_needs_timer, led_reg, timer_reg != 16'd0, "LED lit with expired timer")
    `AFR_ASSERT_NEXT(a_tick_syncs_count, req.tick, seen_reg == $past(req.count), "count not taken on tick")

endmodule

`default_nettype wire

// ===== rtl/core/ascii_frame_receiver_with_error_led.sv =====
// ----------------------------------------------------------------------------
// ASCII frame receiver with error LED
// Collects colon-delimited ASCII frames, checks length and characters, keeps
// a saturating error count and drives a timed error LED.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload                                   | Handshake
//  rx_in    | in        | mode, rx_byte                             | valid/ready
//  res_out  | out       | frame_done, frame_status, error_counted,  | valid/ready
//           |           | error_total, led_lit                      |
//  cfg      | in        | index, data                               | valid/ready
//
//  One request per cycle while results are taken; its result appears in the output
//  register in the cycle after it is accepted. The result register sets the rate.
//  rx_in.ready is high whenever the output register is empty or being taken.
//  cfg.ready is always high. Reset clears or presets all state but the result payload; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ascii_frame_receiver_with_error_led_assert.svh"

module ascii_frame_receiver_with_error_led
    import afr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    afr_in_if.sink    rx_in,
    afr_out_if.source res_out,
    afr_cfg_if.sink   cfg
);

    logic [7:0]  frame_length_reg;
    logic [15:0] led_hold_reg;

    logic [7:0]  index_reg;
    logic [7:0]  index_next;
    logic        bad_reg;
    logic        bad_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;

    result_t     res_reg;
    result_t     res_next;
    logic        res_valid_reg;
    logic        res_valid_next;

    logic          accept;
    logic          err_event;
    logic          counted;
    logic          done;
    frame_status_t status;
    logic [7:0]    index_inc;
    led_req_t      led_req;
    logic          led_lit;

    assign rx_in.ready = !res_valid_reg || res_out.ready;
    assign accept      = rx_in.valid && rx_in.ready;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= RESET_FRAME_LENGTH;
            led_hold_reg     <= RESET_LED_HOLD;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_FRAME_LENGTH: frame_length_reg <= cfg.data[7:0];
                REG_LED_HOLD:     led_hold_reg     <= cfg.data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        index_next = index_reg;
        bad_next   = bad_reg;
        err_event  = 1'b0;
        done       = 1'b0;
        status     = ST_OK;
        index_inc  = index_reg + 8'd1;

        if (accept && !rx_in.mode)
        begin
            if (rx_in.rx_byte == CH_START)
            begin
                // A start mark inside an open frame restarts it and counts an error.
                err_event  = (index_reg != 8'd0);
                index_next = 8'd1;
                bad_next   = 1'b0;
            end
            else if ((index_reg == 8'd0) || (index_reg >= BUFFER_DEPTH))
            begin
                err_event = 1'b1;
            end
            else if (rx_in.rx_byte == CH_NEWLINE)
            begin
                done = 1'b1;
                if (index_inc != frame_length_reg)
                    status = ST_BAD_LENGTH;
                else if (bad_reg)
                    status = ST_BAD_CHAR;
                err_event  = (status != ST_OK);
                index_next = 8'd0;
                bad_next   = 1'b0;
            end
            else
            begin
                index_next = index_inc;
                if (!char_allowed(rx_in.rx_byte))
                    bad_next = 1'b1;
            end
        end

        counted    = err_event && (count_reg != COUNT_MAX);
        count_next = count_reg + {15'd0, counted};
    end

    assign led_req.tick  = accept && rx_in.mode;
    assign led_req.count = count_reg;
    assign led_req.hold  = led_hold_reg;

    afr_led_ctrl u_led_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (led_req),
        .led_lit (led_lit)
    );

    always_comb
    begin
        res_next               = res_reg;
        res_valid_next         = res_valid_reg;
        if (accept)
        begin
            res_next.frame_done    = done;
            res_next.frame_status  = status;
            res_next.error_counted = counted;
            res_next.error_total   = count_next;
            res_next.led_lit       = led_lit;
            res_valid_next         = 1'b1;
        end
        else if (res_out.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg     <= '0;
            bad_reg       <= 1'b0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            index_reg     <= index_next;
            bad_reg       <= bad_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_out.valid         = res_valid_reg;
    assign res_out.frame_done    = res_reg.frame_done;
    assign res_out.frame_status  = res_reg.frame_status;
    assign res_out.error_counted = res_reg.error_counted;
    assign res_out.error_total   = res_reg.error_total;
    assign res_out.led_lit       = res_reg.led_lit;

    `AFR_ASSERT_SAME(a_index_in_buffer, 1'b1, index_reg <= BUFFER_DEPTH, "frame index past buffer")
    `AFR_ASSERT_NEXT(a_count_monotonic, 1'b1, count_reg >= $past(count_reg), "error count fell")
    `AFR_ASSERT_SAME(a_status_needs_done, res_valid_reg && !res_reg.frame_done, res_reg.frame_status == ST_OK, "status without frame end")
    `AFR_ASSERT_SAME(a_counted_total, res_valid_reg && res_reg.error_counted, res_reg.error_total != 16'd0, "error counted with zero total")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the ASCII frame receiver with error LED
// Sends bytes and millisecond ticks through the request channel with random
// gaps, predicts each result from an independent model of framing, the
// saturating error count and the LED timer, and checks every result field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import afr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    afr_in_if  rx_if ();
    afr_out_if res_if ();
    afr_cfg_if cfg_if ();

    ascii_frame_receiver_with_error_led u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_in   (rx_if),
        .res_out (res_if),
        .cfg     (cfg_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted receiver state and register copies.
    logic [7:0]  frm_index;
    logic        payload_bad;
    logic [15:0] err_count;
    logic [15:0] seen_count;
    logic [15:0] led_timer;
    logic        led_on;
    logic [7:0]  cfg_frame_len;
    logic [15:0] cfg_led_hold;

    result_t predicted_results[$];
    int      mismatches  = 0;
    int      items_sent  = 0;
    int      cycles      = 0;
    int      sink_wait   = 0;
    bit      quiet       = 1'b0;

    function automatic logic legal_payload(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c == CH_HASH);
    endfunction

    function automatic logic count_error();
        if (err_count == COUNT_MAX)
        begin
            return 1'b0;
        end
        err_count = err_count + 16'd1;
        return 1'b1;
    endfunction

    function automatic result_t predict_result(input logic m, input logic [7:0] c);
        result_t r;
        r = '0;
        if (m)
        begin
            if (err_count != seen_count)
            begin
                seen_count = err_count;
                led_timer  = cfg_led_hold;
                led_on     = 1'b1;
            end
            if (led_timer != 16'd0)
            begin
                led_timer = led_timer - 16'd1;
            end
            if (led_timer == 16'd0)
            begin
                led_on = 1'b0;
            end
        end
        else if (c == CH_START)
        begin
            if (frm_index != 8'd0)
            begin
                r.error_counted = count_error();
            end
            frm_index   = 8'd1;
            payload_bad = 1'b0;
        end
        else if (frm_index == 8'd0 || frm_index >= BUFFER_DEPTH)
        begin
            // Outside a frame, or the buffer is full and the byte is dropped.
            r.error_counted = count_error();
        end
        else
        begin
            frm_index = frm_index + 8'd1;
            if (c == CH_NEWLINE)
            begin
                r.frame_done = 1'b1;
                if (frm_index != cfg_frame_len)
                begin
                    r.frame_status = ST_BAD_LENGTH;
                end
                else if (payload_bad)
                begin
                    r.frame_status = ST_BAD_CHAR;
                end
                if (r.frame_status != ST_OK)
                begin
                    r.error_counted = count_error();
                end
                frm_index   = 8'd0;
                payload_bad = 1'b0;
            end
            else if (!legal_payload(c))
            begin
                payload_bad = 1'b1;
            end
        end
        r.error_total = err_count;
        r.led_lit     = led_on;
        return r;
    endfunction

    function automatic logic [7:0] legal_char();
        int pick;
        pick = $urandom_range(0, 36);
        if (pick < 10)
        begin
            return 8'("0" + pick);
        end
        if (pick < 36)
        begin
            return 8'("A" + pick - 10);
        end
        return CH_HASH;
    endfunction

    function automatic logic [7:0] illegal_char();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (legal_payload(c) || c == CH_START || c == CH_NEWLINE);
        return c;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Prediction on each accepted request, then the check of each accepted result.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (rx_if.valid && rx_if.ready)
            begin
                predicted_results.push_back(predict_result(rx_if.mode, rx_if.rx_byte));
            end
            if (res_if.valid && res_if.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    compare_field("frame_done", 16'(want.frame_done),
                                  16'(res_if.frame_done));
                    compare_field("frame_status", 16'(want.frame_status),
                                  16'(res_if.frame_status));
                    compare_field("error_counted", 16'(want.error_counted),
                                  16'(res_if.error_counted));
                    compare_field("error_total", want.error_total, res_if.error_total);
                    compare_field("led_lit", 16'(want.led_lit), 16'(res_if.led_lit));
                end
            end
        end
    end

    // Result side: after a result is taken, usually a random stall; none while quiet.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            sink_wait    <= 0;
        end
        else if (res_if.valid && res_if.ready)
        begin
            if (quiet || $urandom_range(0, 7) == 0)
            begin
                res_if.ready <= 1'b1;
            end
            else
            begin
                res_if.ready <= 1'b0;
                sink_wait    <= $urandom_range(1, 7);
            end
        end
        else if (sink_wait > 0)
        begin
            sink_wait    <= sink_wait - 1;
            res_if.ready <= (sink_wait == 1);
        end
        else
        begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic m, input logic [7:0] b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.mode    <= m;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_tick();
        // The byte field carries noise on a tick; the block must ignore it.
        send_request(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_request(1'b0, s[i]);
        end
    endtask

    task automatic drain();
        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (predicted_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_FRAME_LENGTH: cfg_frame_len = value[7:0];
            REG_LED_HOLD:     cfg_led_hold  = value;
        endcase
        @(posedge clk);
    endtask

    task automatic test_reset_values();
        send_text(":09AZ#12345B\n");
        send_text("Q");
        send_tick();
        drain();
    endtask

    task automatic test_frame_checks();
        write_reg(REG_FRAME_LENGTH, 16'hFF04);
        send_text(":A#\n");
        send_text(":/Z\n");
        send_text(":9\n");
        // A start mark in mid-frame counts an error and reopens the frame.
        send_text(":Z:0A\n");
        send_request(1'b0, CH_START);
        send_request(1'b0, 8'h00);
        send_request(1'b0, 8'hFF);
        send_request(1'b0, CH_NEWLINE);
        drain();
    endtask

    task automatic test_full_buffer();
        write_reg(REG_FRAME_LENGTH, 16'h0010);
        send_text(":0123456789ABCD\n");
        // The sixteenth byte fills the buffer; the newline after it is dropped.
        send_text(":0123456789ABCDE\n");
        send_text("#:\n");
        drain();
    endtask

    task automatic test_led_hold();
        logic [15:0] holds [4];
        holds = '{16'd0, 16'd1, 16'd2, 16'hFFFF};
        foreach (holds[i])
        begin
            write_reg(REG_LED_HOLD, holds[i]);
            send_text("Q");
            send_tick();
            send_tick();
            drain();
        end
    endtask

    task automatic test_random_traffic(input logic [7:0] len_setting,
                                       input logic [15:0] hold_setting, input int n);
        int start;
        int kind;
        int len;
        write_reg(REG_FRAME_LENGTH, {8'($urandom_range(0, 255)), len_setting});
        write_reg(REG_LED_HOLD, hold_setting);
        start = items_sent;
        while (items_sent - start < n)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                quiet = ~quiet;
            end
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                // Mostly frames of the set length; some of random length,
                // up to one byte more than the buffer holds.
                if (len_setting <= BUFFER_DEPTH && kind < 5)
                begin
                    len = int'(len_setting);
                end
                else
                begin
                    len = $urandom_range(2, BUFFER_DEPTH + 1);
                end
                send_request(1'b0, CH_START);
                for (int i = 0; i < len - 2; i++)
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        send_tick();
                    end
                    send_request(1'b0, ($urandom_range(0, 15) == 0) ? illegal_char()
                                                                    : legal_char());
                end
                send_request(1'b0, CH_NEWLINE);
            end
            else if (kind == 7)
            begin
                // A frame left open; the next start mark finds it.
                send_request(1'b0, CH_START);
                repeat ($urandom_range(0, 5)) send_request(1'b0, legal_char());
            end
            else if (kind == 8)
            begin
                send_request(1'b0, 8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 3)) send_tick();
            end
        end
        quiet = 1'b0;
        drain();
    endtask

    initial
    begin
        rx_if.valid   = 1'b0;
        rx_if.mode    = 1'b0;
        rx_if.rx_byte = 8'h00;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = REG_FRAME_LENGTH;
        cfg_if.data   = 16'h0000;

        frm_index     = 8'd0;
        payload_bad   = 1'b0;
        err_count     = 16'd0;
        seen_count    = 16'd0;
        led_timer     = 16'd0;
        led_on        = 1'b0;
        cfg_frame_len = RESET_FRAME_LENGTH;
        cfg_led_hold  = RESET_LED_HOLD;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_frame_checks();
        test_full_buffer();
        test_led_hold();
        test_random_traffic(8'd13, 16'd1000, 300);
        test_random_traffic(8'd2, 16'd1, 300);
        test_random_traffic(8'd16, 16'd3, 300);
        test_random_traffic(8'd255, 16'hFFFF, 250);
        test_random_traffic(8'($urandom_range(3, 12)), 16'($urandom_range(0, 30)), 300);
        test_random_traffic(8'($urandom_range(2, 17)), 16'($urandom_range(1, 8)), 300);

        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/afr_pkg.sv
rtl/core/afr_in_if.sv
rtl/core/afr_out_if.sv
rtl/core/afr_cfg_if.sv
rtl/core/afr_led_ctrl.sv
rtl/core/ascii_frame_receiver_with_error_led.sv
bench/tb.sv
